### src/nfb_pkg.sv
// Shared types and constants for the 4bpp framebuffer rectangle fill block.
// No dependencies; used by every module under src.
package nfb_pkg;

  localparam int unsigned DefFrameWidth  = 960;
  localparam int unsigned DefFrameHeight = 540;

  localparam int unsigned CoordW  = 12;
  localparam int unsigned AddrInW = 18;
  localparam int unsigned ActW    = 3;

  localparam logic [7:0] WhiteByte = 8'hFF;

  localparam logic [ActW-1:0] ActFill      = 3'd0;
  localparam logic [ActW-1:0] ActClearDirty = 3'd1;
  localparam logic [ActW-1:0] ActWhite     = 3'd2;
  localparam logic [ActW-1:0] ActMarkDirty = 3'd3;
  localparam logic [ActW-1:0] ActRead      = 3'd4;
  localparam logic [ActW-1:0] ActTakeDirty = 3'd5;

  localparam int unsigned QDepth = 2;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_FILL,
    OP_CLEAR,
    OP_READ
  } op_e;

  typedef enum logic [2:0] {
    BK_INIT,
    BK_IDLE,
    BK_FILL,
    BK_CLEAR,
    BK_READ
  } bk_state_e;

  typedef struct packed {
    op_e                op;
    logic               dirty;
    logic [CoordW-1:0]  x0;
    logic [CoordW-1:0]  x1;
    logic [CoordW-1:0]  y0;
    logic [CoordW-1:0]  y1;
    logic [3:0]         color;
    logic [AddrInW-1:0] addr;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### src/nfb_front.sv
// Command front end: accepts transactions, clips rectangles, tracks the dirty flag.
// Depends on nfb_pkg; pushes classified commands into nfb_queue.
module nfb_front #(
  parameter int unsigned FRAME_WIDTH  = nfb_pkg::DefFrameWidth,
  parameter int unsigned FRAME_HEIGHT = nfb_pkg::DefFrameHeight
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [nfb_pkg::ActW-1:0]         action_i,
  input  logic signed [nfb_pkg::CoordW-1:0] x_start_i,
  input  logic signed [nfb_pkg::CoordW-1:0] y_start_i,
  input  logic [nfb_pkg::CoordW-1:0]       rect_width_i,
  input  logic [nfb_pkg::CoordW-1:0]       rect_height_i,
  input  logic [7:0]                       pixel_color_i,
  input  logic [nfb_pkg::AddrInW-1:0]      read_address_i,
  input  nfb_pkg::q_stat_t                 q_stat_i,
  input  logic                             init_busy_i,
  output logic                             push_o,
  output nfb_pkg::cmd_t                    cmd_o
);

  localparam int unsigned StoreBytes = (FRAME_WIDTH * FRAME_HEIGHT) / 2;
  localparam int unsigned SW = nfb_pkg::CoordW + 2;
  localparam logic signed [SW-1:0] FwS = SW'(FRAME_WIDTH);
  localparam logic signed [SW-1:0] FhS = SW'(FRAME_HEIGHT);

  logic dirty_q, dirty_d;
  logic signed [SW-1:0] xs, ys, xe, ye, x0s, y0s, x1s, y1s;
  logic empty_rect, addr_ok;

  assign busy   = q_stat_i.full | init_busy_i;
  assign push_o = start & ~busy;

  always_comb begin
    xs  = SW'(x_start_i);
    ys  = SW'(y_start_i);
    xe  = xs + $signed({2'b00, rect_width_i});
    ye  = ys + $signed({2'b00, rect_height_i});
    x0s = (xs < 0) ? '0 : xs;
    y0s = (ys < 0) ? '0 : ys;
    x1s = (xe > FwS) ? FwS : xe;
    y1s = (ye > FhS) ? FhS : ye;
    empty_rect = (x0s >= x1s) | (y0s >= y1s);
    addr_ok = 32'(read_address_i) < 32'(StoreBytes);
  end

  always_comb begin
    cmd_o.dirty = dirty_q;
    cmd_o.x0    = x0s[nfb_pkg::CoordW-1:0];
    cmd_o.x1    = x1s[nfb_pkg::CoordW-1:0];
    cmd_o.y0    = y0s[nfb_pkg::CoordW-1:0];
    cmd_o.y1    = y1s[nfb_pkg::CoordW-1:0];
    cmd_o.color = pixel_color_i[7:4];
    cmd_o.addr  = read_address_i;
    cmd_o.op    = nfb_pkg::OP_NONE;
    dirty_d     = dirty_q;
    case (action_i)
      nfb_pkg::ActFill: begin
        if (!empty_rect) cmd_o.op = nfb_pkg::OP_FILL;
      end
      nfb_pkg::ActClearDirty: begin
        cmd_o.op = nfb_pkg::OP_CLEAR;
        dirty_d  = 1'b1;
      end
      nfb_pkg::ActWhite: begin
        cmd_o.op = nfb_pkg::OP_CLEAR;
      end
      nfb_pkg::ActMarkDirty: begin
        dirty_d = 1'b1;
      end
      nfb_pkg::ActRead: begin
        if (addr_ok) cmd_o.op = nfb_pkg::OP_READ;
      end
      nfb_pkg::ActTakeDirty: begin
        dirty_d = 1'b0;
      end
      default: begin
        cmd_o.op = nfb_pkg::OP_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dirty_q <= 1'b0;
    end else if (push_o) begin
      dirty_q <= dirty_d;
    end
  end

endmodule

### src/nfb_queue.sv
// Two-entry command queue between front end and back end.
// Depends on nfb_pkg (cmd_t, q_stat_t, QDepth).
module nfb_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  nfb_pkg::cmd_t    cmd_i,
  input  logic             pop_i,
  output nfb_pkg::cmd_t    head_o,
  output nfb_pkg::q_stat_t stat_o
);

  localparam int unsigned PtrW = $clog2(nfb_pkg::QDepth);
  localparam int unsigned CntW = $clog2(nfb_pkg::QDepth + 1);

  nfb_pkg::cmd_t entry_q [nfb_pkg::QDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign head_o       = entry_q[rd_ptr_q];
  assign stat_o.full  = count_q == CntW'(nfb_pkg::QDepth);
  assign stat_o.empty = count_q == '0;

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= PtrW'(wr_ptr_q + 1'b1);
      if (pop_i)  rd_ptr_q <= PtrW'(rd_ptr_q + 1'b1);
      case ({push_i, pop_i})
        2'b10:   count_q <= CntW'(count_q + 1'b1);
        2'b01:   count_q <= CntW'(count_q - 1'b1);
        default: count_q <= count_q;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !stat_o.full) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty) else $error("pop from empty queue");

endmodule

### src/nfb_back.sv
// Back end: pixel store, fill/clear/read sequencer and result register.
// Depends on nfb_pkg; takes commands from the head of nfb_queue.
module nfb_back #(
  parameter int unsigned FRAME_WIDTH  = nfb_pkg::DefFrameWidth,
  parameter int unsigned FRAME_HEIGHT = nfb_pkg::DefFrameHeight
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  nfb_pkg::cmd_t    head_i,
  input  nfb_pkg::q_stat_t q_stat_i,
  output logic             pop_o,
  output logic             init_busy_o,
  output logic             done_o,
  output logic [7:0]       read_data_o,
  output logic             dirty_out_o
);

  localparam int unsigned RowBytes   = FRAME_WIDTH / 2;
  localparam int unsigned StoreBytes = (FRAME_WIDTH * FRAME_HEIGHT) / 2;
  localparam int unsigned AW = (StoreBytes > 1) ? $clog2(StoreBytes) : 1;
  localparam int unsigned RW = AW + 1;
  localparam int unsigned CW = nfb_pkg::CoordW;

  logic [7:0] mem_q [StoreBytes];
  logic [7:0] rdata_q;

  nfb_pkg::bk_state_e state_q, state_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] x_q, x_d, y_q, y_d;
  logic [RW-1:0] row_q, row_d;
  logic done_q, data_sel;
  logic [7:0] data_q, emit_data;
  logic dirty_q;

  logic          wr_en, rd_en, emit, clr_last;
  logic [1:0]    wr_mask;
  logic [7:0]    wr_data;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [RW-1:0] fill_addr;
  logic          fill_ok;

  assign fill_addr   = row_q + RW'(x_q[CW-1:1]);
  assign fill_ok     = fill_addr < RW'(StoreBytes);
  assign clr_last    = cnt_q == AW'(StoreBytes - 1);
  assign rd_addr     = AW'(head_i.addr);
  assign init_busy_o = state_q == nfb_pkg::BK_INIT;
  assign data_sel    = state_q == nfb_pkg::BK_READ;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    x_d       = x_q;
    y_d       = y_q;
    row_d     = row_q;
    wr_en     = 1'b0;
    wr_mask   = 2'b11;
    wr_data   = nfb_pkg::WhiteByte;
    wr_addr   = cnt_q;
    rd_en     = 1'b0;
    pop_o     = 1'b0;
    emit      = 1'b0;
    case (state_q)
      nfb_pkg::BK_INIT: begin
        wr_en = 1'b1;
        if (clr_last) state_d = nfb_pkg::BK_IDLE;
        else          cnt_d   = AW'(cnt_q + 1'b1);
      end
      nfb_pkg::BK_IDLE: begin
        if (!q_stat_i.empty) begin
          case (head_i.op)
            nfb_pkg::OP_FILL: begin
              x_d     = head_i.x0;
              y_d     = head_i.y0;
              row_d   = RW'(32'(head_i.y0) * 32'(RowBytes));
              state_d = nfb_pkg::BK_FILL;
            end
            nfb_pkg::OP_CLEAR: begin
              cnt_d   = '0;
              state_d = nfb_pkg::BK_CLEAR;
            end
            nfb_pkg::OP_READ: begin
              rd_en   = 1'b1;
              state_d = nfb_pkg::BK_READ;
            end
            default: begin
              emit  = 1'b1;
              pop_o = 1'b1;
            end
          endcase
        end
      end
      nfb_pkg::BK_FILL: begin
        wr_en   = fill_ok;
        wr_addr = fill_addr[AW-1:0];
        wr_mask = x_q[0] ? 2'b10 : 2'b01;
        wr_data = {head_i.color, head_i.color};
        if (CW'(x_q + 1'b1) == head_i.x1) begin
          if (CW'(y_q + 1'b1) == head_i.y1) begin
            emit    = 1'b1;
            pop_o   = 1'b1;
            state_d = nfb_pkg::BK_IDLE;
          end else begin
            y_d   = CW'(y_q + 1'b1);
            x_d   = head_i.x0;
            row_d = row_q + RW'(RowBytes);
          end
        end else begin
          x_d = CW'(x_q + 1'b1);
        end
      end
      nfb_pkg::BK_CLEAR: begin
        wr_en = 1'b1;
        if (clr_last) begin
          emit    = 1'b1;
          pop_o   = 1'b1;
          state_d = nfb_pkg::BK_IDLE;
        end else begin
          cnt_d = AW'(cnt_q + 1'b1);
        end
      end
      nfb_pkg::BK_READ: begin
        emit    = 1'b1;
        pop_o   = 1'b1;
        state_d = nfb_pkg::BK_IDLE;
      end
      default: begin
        state_d = nfb_pkg::BK_IDLE;
      end
    endcase
  end

  assign emit_data = data_sel ? rdata_q : 8'h00;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      if (wr_mask[0]) mem_q[wr_addr][3:0] <= wr_data[3:0];
      if (wr_mask[1]) mem_q[wr_addr][7:4] <= wr_data[7:4];
    end
    if (rd_en) rdata_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nfb_pkg::BK_INIT;
      cnt_q   <= '0;
      x_q     <= '0;
      y_q     <= '0;
      row_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      x_q     <= x_d;
      y_q     <= y_d;
      row_q   <= row_d;
      done_q  <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      data_q  <= emit_data;
      dirty_q <= head_i.dirty;
    end
  end

  assign done_o      = done_q;
  assign read_data_o = data_q;
  assign dirty_out_o = dirty_q;

  a_job_has_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == nfb_pkg::BK_FILL || state_q == nfb_pkg::BK_CLEAR ||
     state_q == nfb_pkg::BK_READ) |-> !q_stat_i.empty)
    else $error("back end busy without a queued command");
  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == nfb_pkg::BK_READ) |=> done_q)
    else $error("read did not produce a result");
  a_init_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == nfb_pkg::BK_INIT) |=> !done_q)
    else $error("result during reset clear");

endmodule

### src/nibble_framebuffer_rect_fill.sv
// Top level of the 4bpp framebuffer with rectangle fill.
// Depends on nfb_pkg, nfb_front, nfb_queue and nfb_back.
//
// Usage: drive a command on the input ports and raise start; the command is
// taken at a rising edge where start is high and busy is low. Every command
// produces exactly one result: done_o is high for one cycle with read_data_o
// and dirty_out_o valid. Results cannot be stalled and come in command order.
// Path from the accepting edge to done_o: flag commands, empty or fully
// clipped fills and out-of-range reads take their result straight from the
// idle back end; a byte read first passes the pixel store's read port (one
// registered port); a fill first writes every in-frame pixel, and a clear to
// white every store byte, (FRAME_WIDTH*FRAME_HEIGHT)/2 of them. The store
// write port writes one pixel nibble per cycle in a fill and a whole byte in a
// clear. A two-entry command queue lets one further command be taken while
// one is being executed. After reset busy stays high while all
// (FRAME_WIDTH*FRAME_HEIGHT)/2 store bytes are swept to white (259200 at
// 960x540); the dirty flag resets to zero.
module nibble_framebuffer_rect_fill #(
  parameter int unsigned FRAME_WIDTH  = nfb_pkg::DefFrameWidth,
  parameter int unsigned FRAME_HEIGHT = nfb_pkg::DefFrameHeight
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [nfb_pkg::ActW-1:0]          action_i,
  input  logic signed [nfb_pkg::CoordW-1:0] x_start_i,
  input  logic signed [nfb_pkg::CoordW-1:0] y_start_i,
  input  logic [nfb_pkg::CoordW-1:0]        rect_width_i,
  input  logic [nfb_pkg::CoordW-1:0]        rect_height_i,
  input  logic [7:0]                        pixel_color_i,
  input  logic [nfb_pkg::AddrInW-1:0]       read_address_i,
  output logic                              done_o,
  output logic [7:0]                        read_data_o,
  output logic                              dirty_out_o
);

  nfb_pkg::cmd_t    cmd, head;
  nfb_pkg::q_stat_t q_stat;
  logic             push, pop, init_busy;

  nfb_front #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .action_i      (action_i),
    .x_start_i     (x_start_i),
    .y_start_i     (y_start_i),
    .rect_width_i  (rect_width_i),
    .rect_height_i (rect_height_i),
    .pixel_color_i (pixel_color_i),
    .read_address_i(read_address_i),
    .q_stat_i      (q_stat),
    .init_busy_i   (init_busy),
    .push_o        (push),
    .cmd_o         (cmd)
  );

  nfb_queue u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .cmd_i (cmd),
    .pop_i (pop),
    .head_o(head),
    .stat_o(q_stat)
  );

  nfb_back #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .q_stat_i   (q_stat),
    .pop_o      (pop),
    .init_busy_o(init_busy),
    .done_o     (done_o),
    .read_data_o(read_data_o),
    .dirty_out_o(dirty_out_o)
  );

endmodule
